// ===== rtl/css_pkg.sv =====
package css_pkg;

	localparam int BTN_W      = 8;
	localparam int POT_FIELDS = 4;
	localparam int RAW_W      = 16;
	localparam int POT_OUT_W  = 13;
	localparam int SMOOTH_W   = 17;
	localparam int ALPHA_W    = 16;
	localparam int THR_W      = 17;
	localparam int ENC_W      = 8;
	localparam int MIDI_W     = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_SHIFT = 4;
	localparam int PROD_W     = SMOOTH_W + ALPHA_W;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

	localparam logic [ALPHA_W-1:0]   ALPHA_RESET    = 16'd22938;
	localparam logic [THR_W-1:0]     THR_RESET      = 17'd66;
	localparam logic [POT_OUT_W-1:0] POT_FULL_SCALE = 13'd4096;
	localparam logic [PROD_W-1:0]    ROUND_HALF     = PROD_W'(32768);
	localparam logic [SMOOTH_W:0]    OUT_ROUND      = (SMOOTH_W + 1)'(8);

	typedef struct packed {
		logic                 seen;
		logic                 changed;
		logic [POT_OUT_W-1:0] pot;
	} lane_res_t;

	typedef struct packed {
		logic [BTN_W-1:0]                      pressed_mask;
		logic [BTN_W-1:0]                      press_edges;
		logic [POT_FIELDS-1:0]                 pot_seen_mask;
		logic [POT_FIELDS-1:0][POT_OUT_W-1:0]  pot_out;
		logic signed [ENC_W-1:0]               encoder_out;
		logic                                  frame_changed;
	} frame_res_t;

endpackage

// ===== rtl/css_pot_lane.sv =====
module css_pot_lane import css_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic signed [RAW_W-1:0]  raw,
	input  logic [ALPHA_W-1:0]       alpha,
	input  logic [THR_W-1:0]         threshold,
	output lane_res_t                res
);

	logic [SMOOTH_W-1:0]  smooth_q;
	logic                 seen_q;
	logic [POT_OUT_W-1:0] clamped;
	logic [SMOOTH_W-1:0]  target;
	logic [SMOOTH_W:0]    diff;
	logic [SMOOTH_W:0]    diff_neg;
	logic                 neg;
	logic [SMOOTH_W-1:0]  abs_diff;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    prod_rnd;
	logic [SMOOTH_W-1:0]  mag;
	logic [SMOOTH_W-1:0]  smooth_next;
	logic [SMOOTH_W-1:0]  smooth_shown;
	logic [SMOOTH_W:0]    shown_rnd;

	always_comb begin
		if (raw[RAW_W-1]) begin
			clamped = '0;
		end else if (raw > $signed({3'b000, POT_FULL_SCALE})) begin
			clamped = POT_FULL_SCALE;
		end else begin
			clamped = raw[POT_OUT_W-1:0];
		end
	end

	assign target   = {clamped, {FRAC_SHIFT{1'b0}}};
	assign diff     = {1'b0, target} - {1'b0, smooth_q};
	assign diff_neg = -diff;
	assign neg      = diff[SMOOTH_W];
	assign abs_diff = neg ? diff_neg[SMOOTH_W-1:0] : diff[SMOOTH_W-1:0];

	// Magnitude times alpha, rounded half away from zero by rounding the magnitude.
	assign prod     = {{ALPHA_W{1'b0}}, abs_diff} * {{SMOOTH_W{1'b0}}, alpha};
	assign prod_rnd = prod + ROUND_HALF;
	assign mag      = prod_rnd[PROD_W-1:ALPHA_W];

	always_comb begin
		if (!seen_q) begin
			smooth_next = target;
		end else if (neg) begin
			smooth_next = smooth_q - mag;
		end else begin
			smooth_next = smooth_q + mag;
		end
	end

	assign smooth_shown = load ? smooth_next : smooth_q;
	assign shown_rnd    = {1'b0, smooth_shown} + OUT_ROUND;

	assign res.seen    = seen_q | load;
	assign res.changed = load & (~seen_q | (mag >= threshold));
	assign res.pot     = shown_rnd[SMOOTH_W-1:FRAC_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			seen_q   <= 1'b0;
		end else if (load) begin
			smooth_q <= smooth_next;
			seen_q   <= 1'b1;
		end
	end

endmodule

// ===== rtl/css_merge.sv =====
module css_merge import css_pkg::*; #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [BTN_W-1:0]                   levels,
	input  lane_res_t [POT_FIELDS-1:0]         lanes,
	input  logic signed [ENC_W-1:0]            encoder,
	input  logic [MIDI_W-1:0]                  midi,
	output frame_res_t                         res
);

	localparam int BTN_USED = (BUTTON_COUNT < BTN_W) ? BUTTON_COUNT : BTN_W;
	localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << BTN_USED) - 64'd1);

	logic [BTN_W-1:0]      last_levels_q;
	logic [BTN_W-1:0]      levels_m;
	logic [POT_FIELDS-1:0] lane_changed;

	assign levels_m = levels & BTN_MASK;

	for (genvar i = 0; i < POT_FIELDS; i++) begin : g_pick
		assign res.pot_seen_mask[i] = lanes[i].seen;
		assign res.pot_out[i]       = lanes[i].pot;
		assign lane_changed[i]      = lanes[i].changed;
	end

	assign res.pressed_mask  = levels_m;
	assign res.press_edges   = levels_m & ~last_levels_q;
	assign res.encoder_out   = encoder;
	assign res.frame_changed = (levels_m != last_levels_q) | (|lane_changed) |
		(encoder != '0) | (midi != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q <= '0;
		end else if (accept) begin
			last_levels_q <= levels_m;
		end
	end

endmodule

// ===== rtl/css_out_buf.sv =====
module css_out_buf import css_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_res_t push_data,
	output logic       full,
	output logic       out_valid,
	input  logic       out_stall,
	output frame_res_t out_data
);

	frame_res_t main_q;
	frame_res_t skid_q;
	logic       main_valid_q;
	logic       skid_valid_q;
	logic       take;

	assign take      = main_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || take) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload path: the skid word moves up when the main word is taken.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || take) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// ===== rtl/control_surface_scanner_top.sv =====
// Each accepted frame's result word is registered into the output buffer in order.
// Throughput: one frame per cycle while in_stall is low; each pot lane closes its multiply,
// round and accumulate recurrence combinationally, so frames can follow back to back.
// A two-word output buffer lets input acceptance continue into an output stall until full.
// Reset (arst_n low, asynchronous) clears button history, smoothed pot values,
// seen flags and the output buffer, and loads the register defaults.
module control_surface_scanner_top import css_pkg::*; #(
	parameter int BUTTON_COUNT = 8,
	parameter int POT_COUNT    = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [BTN_W-1:0]         button_levels,
	input  logic [POT_FIELDS-1:0]    pot_present,
	input  logic signed [RAW_W-1:0]  pot_raw_0,
	input  logic signed [RAW_W-1:0]  pot_raw_1,
	input  logic signed [RAW_W-1:0]  pot_raw_2,
	input  logic signed [RAW_W-1:0]  pot_raw_3,
	input  logic signed [ENC_W-1:0]  encoder_step,
	input  logic [MIDI_W-1:0]        midi_waiting,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [BTN_W-1:0]         pressed_mask,
	output logic [BTN_W-1:0]         press_edges,
	output logic [POT_FIELDS-1:0]    pot_seen_mask,
	output logic [POT_OUT_W-1:0]     pot_out_0,
	output logic [POT_OUT_W-1:0]     pot_out_1,
	output logic [POT_OUT_W-1:0]     pot_out_2,
	output logic [POT_OUT_W-1:0]     pot_out_3,
	output logic signed [ENC_W-1:0]  encoder_out,
	output logic                     frame_changed,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	logic [ALPHA_W-1:0]                 alpha_q;
	logic [THR_W-1:0]                   threshold_q;
	logic                               accept;
	logic signed [POT_FIELDS-1:0][RAW_W-1:0] raw_vec;
	lane_res_t [POT_FIELDS-1:0]         lane_res;
	frame_res_t                         frame_res;
	frame_res_t                         out_res;

	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RESET;
			threshold_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ALPHA) begin
				alpha_q <= cfg_data[ALPHA_W-1:0];
			end else if (cfg_index == REG_THRESHOLD) begin
				threshold_q <= cfg_data[THR_W-1:0];
			end
		end
	end

	assign raw_vec[0] = pot_raw_0;
	assign raw_vec[1] = pot_raw_1;
	assign raw_vec[2] = pot_raw_2;
	assign raw_vec[3] = pot_raw_3;

	for (genvar i = 0; i < POT_FIELDS; i++) begin : g_lane
		if (i < POT_COUNT) begin : g_on
			css_pot_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (accept & pot_present[i]),
				.raw       (raw_vec[i]),
				.alpha     (alpha_q),
				.threshold (threshold_q),
				.res       (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	css_merge #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.levels  (button_levels),
		.lanes   (lane_res),
		.encoder (encoder_step),
		.midi    (midi_waiting),
		.res     (frame_res)
	);

	css_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (frame_res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign pressed_mask  = out_res.pressed_mask;
	assign press_edges   = out_res.press_edges;
	assign pot_seen_mask = out_res.pot_seen_mask;
	assign pot_out_0     = out_res.pot_out[0];
	assign pot_out_1     = out_res.pot_out[1];
	assign pot_out_2     = out_res.pot_out[2];
	assign pot_out_3     = out_res.pot_out[3];
	assign encoder_out   = out_res.encoder_out;
	assign frame_changed = out_res.frame_changed;

	// The buffer only fills its second word while the first is still waiting.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no word waiting at the output");

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted frame did not produce an output word");

	a_pot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pot_out_0 <= POT_FULL_SCALE) && (pot_out_1 <= POT_FULL_SCALE) &&
			(pot_out_2 <= POT_FULL_SCALE) && (pot_out_3 <= POT_FULL_SCALE))
		else $error("smoothed pot value above full scale");

	a_edges_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((press_edges & ~pressed_mask) == '0))
		else $error("press edge reported for a released button");

endmodule

// ===== test/tb_control_surface_scanner_top.sv =====
`timescale 1ns / 100ps

module tb_control_surface_scanner_top;
	import css_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(255);

	typedef struct packed {
		logic [BTN_W-1:0]                  levels;
		logic [POT_FIELDS-1:0]             present;
		logic [POT_FIELDS-1:0][RAW_W-1:0]  raw;
		logic signed [ENC_W-1:0]           encoder;
		logic [MIDI_W-1:0]                 midi;
	} scan_frame_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [BTN_W-1:0]         button_levels;
	logic [POT_FIELDS-1:0]    pot_present;
	logic signed [RAW_W-1:0]  pot_raw_0;
	logic signed [RAW_W-1:0]  pot_raw_1;
	logic signed [RAW_W-1:0]  pot_raw_2;
	logic signed [RAW_W-1:0]  pot_raw_3;
	logic signed [ENC_W-1:0]  encoder_step;
	logic [MIDI_W-1:0]        midi_waiting;
	logic                     out_valid;
	logic                     out_stall;
	logic [BTN_W-1:0]         pressed_mask;
	logic [BTN_W-1:0]         press_edges;
	logic [POT_FIELDS-1:0]    pot_seen_mask;
	logic [POT_OUT_W-1:0]     pot_out_0;
	logic [POT_OUT_W-1:0]     pot_out_1;
	logic [POT_OUT_W-1:0]     pot_out_2;
	logic [POT_OUT_W-1:0]     pot_out_3;
	logic signed [ENC_W-1:0]  encoder_out;
	logic                     frame_changed;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	// Shadow copy of the scanner state and its registers.
	logic [BTN_W-1:0]      prev_levels;
	logic [SMOOTH_W-1:0]   pot_state [POT_FIELDS];
	logic [POT_FIELDS-1:0] seen_pots;
	logic [ALPHA_W-1:0]    alpha_q16;
	logic [THR_W-1:0]      threshold_q17;

	frame_res_t  pending_results[$];
	int          error_count = 0;
	int          frames_sent = 0;
	int          results_checked = 0;
	int          changed_seen = 0;
	int          reg_writes = 0;
	int          cycle_count = 0;
	int          hold_off_left = 0;
	int          stall_left = 0;
	bit          no_idle = 0;

	control_surface_scanner_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.button_levels (button_levels),
		.pot_present   (pot_present),
		.pot_raw_0     (pot_raw_0),
		.pot_raw_1     (pot_raw_1),
		.pot_raw_2     (pot_raw_2),
		.pot_raw_3     (pot_raw_3),
		.encoder_step  (encoder_step),
		.midi_waiting  (midi_waiting),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pressed_mask  (pressed_mask),
		.press_edges   (press_edges),
		.pot_seen_mask (pot_seen_mask),
		.pot_out_0     (pot_out_0),
		.pot_out_1     (pot_out_1),
		.pot_out_2     (pot_out_2),
		.pot_out_3     (pot_out_3),
		.encoder_out   (encoder_out),
		.frame_changed (frame_changed),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out with %0d result words outstanding.", pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Most gaps are short, a few are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic frame_res_t scan_predict(input scan_frame_t f);
		frame_res_t r;
		logic       changed;
		longint     raw_v, target, diff, prod, mag;
		changed = (f.encoder != 0) || (f.midi != 0);
		r.pressed_mask = f.levels;
		r.press_edges = f.levels & ~prev_levels;
		if (f.levels != prev_levels)
			changed = 1'b1;
		prev_levels = f.levels;
		for (int p = 0; p < POT_FIELDS; p++) begin
			if (f.present[p]) begin
				raw_v = longint'($signed(f.raw[p]));
				if (raw_v < 0)
					raw_v = 0;
				if (raw_v > 4096)
					raw_v = 4096;
				target = raw_v * 16;
				if (!seen_pots[p]) begin
					pot_state[p] = SMOOTH_W'(target);
					seen_pots[p] = 1'b1;
					changed = 1'b1;
				end else begin
					diff = target - longint'(pot_state[p]);
					prod = diff * longint'(alpha_q16);
					mag = (prod < 0) ? -prod : prod;
					mag = (mag + 32768) >> 16;
					pot_state[p] = SMOOTH_W'(longint'(pot_state[p]) + ((prod < 0) ? -mag : mag));
					if (mag >= longint'(threshold_q17))
						changed = 1'b1;
				end
			end
			r.pot_out[p] = POT_OUT_W'(((SMOOTH_W + 1)'(pot_state[p]) + OUT_ROUND) >> FRAC_SHIFT);
		end
		r.pot_seen_mask = seen_pots;
		r.encoder_out = f.encoder;
		r.frame_changed = changed;
		return r;
	endfunction

	// Called at a falling edge; returns at a falling edge with the gap already taken.
	task automatic send_frame(input scan_frame_t f);
		int gap;
		in_valid      <= 1'b1;
		button_levels <= f.levels;
		pot_present   <= f.present;
		pot_raw_0     <= f.raw[0];
		pot_raw_1     <= f.raw[1];
		pot_raw_2     <= f.raw[2];
		pot_raw_3     <= f.raw[3];
		encoder_step  <= f.encoder;
		midi_waiting  <= f.midi;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(scan_predict(f));
		frames_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// The sender stops and waits for every outstanding word to come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_ALPHA)
			alpha_q16 = data[ALPHA_W-1:0];
		else if (idx == REG_THRESHOLD)
			threshold_q17 = data[THR_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic scan_frame_t make_frame(input logic [7:0] lv, input logic [3:0] pr,
			input int r0, input int r1, input int r2, input int r3,
			input int enc, input int midi);
		scan_frame_t f;
		f.levels = lv;
		f.present = pr;
		f.raw[0] = RAW_W'(r0);
		f.raw[1] = RAW_W'(r1);
		f.raw[2] = RAW_W'(r2);
		f.raw[3] = RAW_W'(r3);
		f.encoder = ENC_W'(enc);
		f.midi = MIDI_W'(midi);
		return f;
	endfunction

	function automatic logic [RAW_W-1:0] rand_raw(input int p);
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return RAW_W'($urandom_range(0, 4096));
		else if (r < 65)
			// Near the current smoothed value, so that small steps and quiet frames occur.
			return RAW_W'(int'(pot_state[p] >> 4) + int'($urandom_range(0, 16)) - 8);
		else if (r < 85)
			return $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 10) - 5)
			                            : RAW_W'($urandom_range(4090, 4102));
		return RAW_W'($urandom);
	endfunction

	function automatic scan_frame_t rand_frame();
		scan_frame_t f;
		bit          quiet;
		quiet = ($urandom_range(0, 3) == 0);
		f.present = POT_FIELDS'($urandom);
		for (int p = 0; p < POT_FIELDS; p++)
			f.raw[p] = rand_raw(p);
		if (quiet) begin
			f.levels = prev_levels;
			f.encoder = '0;
			f.midi = '0;
		end else begin
			f.levels = $urandom_range(0, 1) ? BTN_W'($urandom)
			                                : prev_levels ^ (BTN_W'(1) << $urandom_range(0, 7));
			f.encoder = $urandom_range(0, 1) ? ENC_W'($urandom) : '0;
			f.midi = ($urandom_range(0, 4) < 2) ? MIDI_W'($urandom) : '0;
		end
		return f;
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_frame(rand_frame());
	endtask

	always @(posedge clk) begin
		frame_res_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.pressed_mask  = pressed_mask;
			got.press_edges   = press_edges;
			got.pot_seen_mask = pot_seen_mask;
			got.pot_out[0]    = pot_out_0;
			got.pot_out[1]    = pot_out_1;
			got.pot_out[2]    = pot_out_2;
			got.pot_out[3]    = pot_out_3;
			got.encoder_out   = encoder_out;
			got.frame_changed = frame_changed;
			if (pending_results.size() == 0) begin
				$error("Result word arrived with no frame outstanding.");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.frame_changed)
					changed_seen++;
				if (got.pressed_mask !== want.pressed_mask) begin
					$error("pressed_mask: expected %0h, got %0h", want.pressed_mask, got.pressed_mask);
					error_count++;
				end
				if (got.press_edges !== want.press_edges) begin
					$error("press_edges: expected %0h, got %0h", want.press_edges, got.press_edges);
					error_count++;
				end
				if (got.pot_seen_mask !== want.pot_seen_mask) begin
					$error("pot_seen_mask: expected %0h, got %0h",
						want.pot_seen_mask, got.pot_seen_mask);
					error_count++;
				end
				for (int p = 0; p < POT_FIELDS; p++) begin
					if (got.pot_out[p] !== want.pot_out[p]) begin
						$error("pot_out_%0d: expected %0d, got %0d", p, want.pot_out[p], got.pot_out[p]);
						error_count++;
					end
				end
				if (got.encoder_out !== want.encoder_out) begin
					$error("encoder_out: expected %0d, got %0d", want.encoder_out, got.encoder_out);
					error_count++;
				end
				if (got.frame_changed !== want.frame_changed) begin
					$error("frame_changed: expected %0b, got %0b",
						want.frame_changed, got.frame_changed);
					error_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic test_directed_frames();
		// A frame with nothing in it right after reset must not count as a change.
		send_frame(make_frame(8'h00, 4'h0, 0, 0, 0, 0, 0, 0));
		send_frame(make_frame(8'hFF, 4'h0, 0, 0, 0, 0, 0, 0));
		send_frame(make_frame(8'h55, 4'h0, 0, 0, 0, 0, 0, 0));
		send_frame(make_frame(8'hAA, 4'h0, 0, 0, 0, 0, 0, 0));
		// First samples, including readings outside the clamp range.
		send_frame(make_frame(8'hAA, 4'h3, -32768, 32767, 100, 100, 0, 0));
		send_frame(make_frame(8'hAA, 4'hC, 0, 0, 4097, -1, 0, 0));
		send_frame(make_frame(8'hAA, 4'hF, 4096, 0, 0, 4096, 0, 0));
		send_frame(make_frame(8'hAA, 4'h5, 0, 9999, 4096, 9999, 0, 0));
		send_frame(make_frame(8'hAA, 4'h0, 4096, 4096, 4096, 4096, -128, 0));
		send_frame(make_frame(8'hAA, 4'h0, 0, 0, 0, 0, 127, 0));
		send_frame(make_frame(8'hAA, 4'h0, 0, 0, 0, 0, 0, 15));
		send_frame(make_frame(8'hAA, 4'h0, 0, 0, 0, 0, 1, 1));
		send_frame(make_frame(8'h00, 4'hF, 2048, 2048, 2048, 2048, 0, 0));
		for (int i = 0; i < 6; i++)
			send_frame(make_frame(8'h00, 4'hF, 2049, 2047, 2048, 2050, 0, 0));
		send_frame(make_frame(8'h00, 4'hF, 32767, -32768, 4096, 0, 0, 0));
		send_frame(make_frame(8'h01, 4'h8, 0, 0, 0, -32768, 0, 0));
		send_frame(make_frame(8'h80, 4'h0, 0, 0, 0, 0, 0, 0));
		drain_results();
	endtask

	task automatic test_register_settings();
		write_reg(REG_ALPHA, '0);
		write_reg(REG_THRESHOLD, '0);
		send_random(110);
		drain_results();
		write_reg(REG_ALPHA, CFG_DATA_W'(65535));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(65536));
		send_random(110);
		drain_results();
		// Threshold above full scale: no smoothing step can count.
		write_reg(REG_ALPHA, CFG_DATA_W'(1));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(17'h1FFFF));
		send_random(110);
		drain_results();
		// Upper data bits must be dropped.
		write_reg(REG_ALPHA, 32'hABCD_8000);
		write_reg(REG_THRESHOLD, 32'hFFFE_0001);
		send_random(110);
		drain_results();
		// Writes to unused indexes leave the registers alone.
		write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED_HI, 32'h0000_1234);
		send_random(110);
		drain_results();
		write_reg(REG_ALPHA, CFG_DATA_W'(ALPHA_RESET));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(THR_RESET));
	endtask

	task automatic test_random_frames();
		send_random(400);
		// A stretch with no idling on either side.
		no_idle = 1;
		send_random(150);
		no_idle = 0;
		send_random(400);
		drain_results();
	endtask

	task automatic test_backpressure();
		hold_off_left = 200;
		no_idle = 1;
		send_random(60);
		no_idle = 0;
		drain_results();
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
		write_reg(REG_ALPHA, CFG_DATA_W'($urandom));
		send_random(80);
		drain_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		button_levels = '0;
		pot_present   = '0;
		pot_raw_0     = '0;
		pot_raw_1     = '0;
		pot_raw_2     = '0;
		pot_raw_3     = '0;
		encoder_step  = '0;
		midi_waiting  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		prev_levels   = '0;
		seen_pots     = '0;
		alpha_q16     = ALPHA_RESET;
		threshold_q17 = THR_RESET;
		for (int p = 0; p < POT_FIELDS; p++)
			pot_state[p] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_register_settings();
		test_random_frames();
		test_backpressure();

		repeat (10) @(negedge clk);
		$display("Sent %0d scan frames and checked %0d result words, %0d of them flagged changed.",
			frames_sent, results_checked, changed_seen);
		$display("Made %0d register writes, covering alpha and threshold extremes and unused indexes.",
			reg_writes);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
